// ===== rtl/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes for the sorted list engine: operation and status
// codes, field widths and the control word broadcast to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  // Broadcast to all cells in the cycle of a transfer.
  typedef struct packed {
    logic                      ins;    // insert with room left
    logic                      del;    // remove of a present value
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sle_req_if.sv =====
// ----------------------------------------------------------------------------
// sle_req_if
// Request channel: one operation per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sle_req_if import sle_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [VALUE_W-1:0] value;
  logic [INDEX_W-1:0]        index;

  modport source (output valid, output op, output value, output index, input ready);
  modport sink   (input valid, input op, input value, input index, output ready);
endinterface

`default_nettype wire

// ===== rtl/sle_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sle_rsp_if
// Response channel: one result per request, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sle_rsp_if import sle_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic                      found;
  logic signed [VALUE_W-1:0] read_value;
  logic [COUNT_W-1:0]        count;
  logic                      is_full;
  logic                      is_empty;

  modport source (output valid, output status, output found, output read_value,
                  output count, output is_full, output is_empty, input ready);
  modport sink   (input valid, input status, input found, input read_value,
                  input count, input is_full, input is_empty, output ready);
endinterface

`default_nettype wire

// ===== rtl/sle_cell.sv =====
// ----------------------------------------------------------------------------
// sle_cell
// One slot of the sorted store. Compares its entry with the broadcast value
// and, on insert, takes the left neighbor's entry or the new value; on
// remove, takes the right neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_cell import sle_pkg::*; (
  input  wire logic                      clk,
  input  wire cell_ctrl_t                ctrl,
  input  wire logic                      occ,
  input  wire logic                      prev_gt,
  input  wire logic signed [VALUE_W-1:0] prev_value,
  input  wire logic signed [VALUE_W-1:0] next_value,
  output logic                           gt,
  output logic                           eq,
  output logic signed [VALUE_W-1:0]      value
);

  logic ge;

  assign gt = occ && (ctrl.value < value);
  assign eq = occ && (ctrl.value == value);
  assign ge = occ && !(value < ctrl.value);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      // open a gap: larger entries move right, new value lands at the boundary
      if (prev_gt) begin
        value <= prev_value;
      end else if (gt || !occ) begin
        value <= ctrl.value;
      end
    end else if (ctrl.del && ge) begin
      // close the gap from the first match onward
      value <= next_value;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// sorted_list_engine_core
// Ordered store of signed 32-bit values built as a row of compare-and-shift
// cells, with insert, remove, search and read-at-index operations.
//
//   channel  dir  fields                                          handshake
//   req      in   op, value, index                                valid/ready
//   rsp      out  status, found, read_value, count, is_full,      valid/ready
//                 is_empty
//
// One request per cycle while req.ready is high: every cell compares and
// shifts in the cycle of the transfer, and the result is loaded into the
// output register; req.ready is high while it is empty or being drained.
// rsp.ready low holds the result; at most one result is ever outstanding.
// Reset clears the entry count and the output valid; entries need no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_engine_core import sle_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  sle_req_if.sink   req,
  sle_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic                      accept;
  logic                      full;
  logic                      empty;
  logic                      found_any;
  logic                      in_range;
  logic signed [VALUE_W-1:0] rd_sel;
  cell_ctrl_t                ctrl;
  status_t                   status_next;
  logic                      found_next;
  logic signed [VALUE_W-1:0] rd_next;

  logic [CAPACITY-1:0]               gt_vec;
  logic [CAPACITY-1:0]               eq_vec;
  logic [CAPACITY-1:0]               occ_vec;
  logic [CAPACITY-1:0]               hit_vec;
  logic signed [VALUE_W-1:0]         cell_value [CAPACITY];

  assign accept    = req.valid && req.ready;
  assign req.ready = !rsp.valid || rsp.ready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign found_any = |eq_vec;
  assign in_range  = (CMP_W'(req.index) < CMP_W'(count));

  assign ctrl.value = req.value;
  assign ctrl.ins   = accept && (op_t'(req.op) == OP_INSERT) && !full;
  assign ctrl.del   = accept && (op_t'(req.op) == OP_REMOVE) && found_any;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] POS     = CNT_W'(i);
    localparam logic [CMP_W-1:0] POS_CMP = CMP_W'(i);

    assign occ_vec[i] = (POS < count);
    assign hit_vec[i] = (POS_CMP == CMP_W'(req.index));

    sle_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ_vec[i]),
      .prev_gt    ((i == 0) ? 1'b0 : gt_vec[(i == 0) ? 0 : i - 1]),
      .prev_value (cell_value[(i == 0) ? 0 : i - 1]),
      .next_value (cell_value[(i == CAPACITY - 1) ? i : i + 1]),
      .gt         (gt_vec[i]),
      .eq         (eq_vec[i]),
      .value      (cell_value[i])
    );
  end

  // Select the indexed entry; at most one hit bit is set.
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_vec[i]) begin
        rd_sel = rd_sel | cell_value[i];
      end
    end
  end

  always_comb begin
    status_next = ST_OK;
    found_next  = 1'b0;
    rd_next     = '0;
    count_next  = count;
    unique case (op_t'(req.op))
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (found_any) begin
          found_next = 1'b1;
          count_next = count - CNT_W'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_SEARCH: begin
        if (found_any) begin
          found_next = 1'b1;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_READ: begin
        if (in_range) begin
          rd_next = rd_sel;
        end else begin
          status_next = ST_RANGE;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Result payload loads on every transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status     <= status_next;
      rsp.found      <= found_next;
      rsp.read_value <= rd_next;
      rsp.count      <= COUNT_W'(count_next);
      rsp.is_full    <= (count_next == CNT_W'(CAPACITY));
      rsp.is_empty   <= (count_next == '0);
    end
  end

endmodule

`default_nettype wire
